FILE: rtl/period_audio_statistics_core_defines.svh
// ---------------------------------------------------------------------------
// period audio statistics: assertion macros
// Shared assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PERIOD_AUDIO_STATISTICS_CORE_DEFINES_SVH
`define PERIOD_AUDIO_STATISTICS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PAS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("period statistics assertion failed");
// next-cycle implication
`define PAS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("period statistics assertion failed");
`else
`define PAS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PAS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/pas_pkg.sv
// ---------------------------------------------------------------------------
// pas_pkg
// Field widths, sequencer codes and control structs of the period statistics.
// ---------------------------------------------------------------------------
`default_nettype none

package pas_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int LEN_W     = 13;
  localparam int MAX_W     = 16;
  localparam int MEAN_W    = 24;
  localparam int SUM_W     = 28;
  localparam int DELTA_W   = 29;
  localparam int TURN_W    = 12;
  localparam int RATE_W    = 18;
  localparam int PAYLOAD_W = LEN_W + MAX_W + MEAN_W + SUM_W + DELTA_W + TURN_W + RATE_W;
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  // sequencer states
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_MAG  = 4'd1;
  localparam logic [ST_W-1:0] ST_PEAK = 4'd2;
  localparam logic [ST_W-1:0] ST_AACC = 4'd3;
  localparam logic [ST_W-1:0] ST_DIFF = 4'd4;
  localparam logic [ST_W-1:0] ST_DACC = 4'd5;
  localparam logic [ST_W-1:0] ST_DIVM = 4'd6;
  localparam logic [ST_W-1:0] ST_DIVF = 4'd7;
  localparam logic [ST_W-1:0] ST_DONE = 4'd8;

  // shared unit operations
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // direction of the waveform
  localparam logic [1:0] TR_NONE = 2'd0;
  localparam logic [1:0] TR_UP   = 2'd1;
  localparam logic [1:0] TR_DOWN = 2'd2;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic accept;
    logic last;
    logic full;
    logic out_free;
  } pas_stat_t;

  // sequencer outputs to the datapath
  typedef struct packed {
    logic [ST_W-1:0] state;
    logic            step_last;
    logic            div_start;
  } pas_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/period_audio_statistics_core.sv
// ---------------------------------------------------------------------------
// period_audio_statistics_core
// Per-period statistics of a signed audio stream, one result word per period.
// ---------------------------------------------------------------------------
// Input channel s_*: one sample per word in s_tdata, s_tlast marks the last
// sample of a period. Output channel m_*: one statistics word per period,
// m_tuser carries the overlong-period flag. cfg_we/cfg_wdata set the sample
// rate used for the frequency field; write it only while the block is idle.
// The magnitude, peak, sum and delta steps share one adder/subtractor under
// a small sequencer: after acceptance a sample runs through MAG, PEAK, AACC,
// DIFF and DACC, and the next sample is taken only back in IDLE. Samples
// beyond MAX_LENGTH skip these steps and only set the overlong flag. On the
// last sample two restoring divisions (mean, then frequency) run one quotient
// bit per cycle on the same adder, then the result word is loaded into the
// output register. If m_tready is low the finished result waits in the output
// register while the next period is already accepted; only a further period
// end stalls until that word is taken. Reset clears all period state, drops
// m_tvalid and restores a sample rate of 48000.
// ---------------------------------------------------------------------------
`default_nettype none

`include "period_audio_statistics_core_defines.svh"

module period_audio_statistics_core
  import pas_pkg::*;
#(
  parameter int MAX_LENGTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [RATE_W-1:0]  cfg_wdata,   // sample_rate
  // sample input
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [SAMPLE_W-1:0] s_tdata,    // sample
  input  wire logic               s_tlast,     // last_sample
  // result output
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // period_length, max_abs, mean_abs_q8, sum_abs, delta_sum, turning_points,
  // frequency_hz, zero fill
  output logic [TDATA_W-1:0]      m_tdata,
  output logic                    m_tuser      // too_long
);

  localparam int CW   = $clog2(MAX_LENGTH + 1);
  localparam int SUMW = CW + SAMPLE_W - 1;
  localparam int AW   = CW + SAMPLE_W;
  localparam int QW   = SUMW + 8;

  pas_stat_t stat;
  pas_ctrl_t ctl;

  // running period state
  logic [RATE_W-1:0]   rate;
  logic [CW-1:0]       count;
  logic [SUMW-1:0]     sum;
  logic [AW-1:0]       delta;
  logic [SAMPLE_W-1:0] peak;
  logic [SAMPLE_W-1:0] prev;
  logic [1:0]          trend;
  logic [CW-1:0]       turn;
  logic                ovf;

  // per-sample and division working registers
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] mag;
  logic [DIFF_W-1:0]   diff;
  logic [CW-1:0]       rem;
  logic [QW-1:0]       dvd;
  logic [QW-1:0]       quo;
  logic [MEAN_W-1:0]   mean;
  logic [RATE_W-1:0]   freq;

  // shared unit ports
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_op;
  logic [AW:0]   alu_res;

  logic [CW:0]   partial;
  logic          q_bit;
  logic [QW-1:0] quo_next;
  logic          nonzero;
  logic [1:0]    dir;
  logic          out_free;

  assign s_tready = (ctl.state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign stat.accept   = s_tvalid && s_tready;
  assign stat.last     = s_tlast;
  assign stat.full     = (count == CW'(MAX_LENGTH));
  assign stat.out_free = out_free;

  pas_ctrl #(
    .QW(QW)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .ctl (ctl)
  );

  pas_addsub #(
    .W(AW)
  ) u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .res(alu_res)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = OP_ADD;
    case (ctl.state)
      ST_MAG: begin
        alu_b  = {{(AW-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        alu_op = smp[SAMPLE_W-1] ? OP_SUB : OP_ADD;
      end
      ST_PEAK: begin
        alu_a  = {{(AW-SAMPLE_W){1'b0}}, peak};
        alu_b  = {{(AW-SAMPLE_W){1'b0}}, mag};
        alu_op = OP_SUB;
      end
      ST_AACC: begin
        alu_a  = {{(AW-SUMW){1'b0}}, sum};
        alu_b  = {{(AW-SAMPLE_W){1'b0}}, mag};
        alu_op = OP_ADD;
      end
      ST_DIFF: begin
        alu_a  = {{(AW-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        alu_b  = {{(AW-SAMPLE_W){prev[SAMPLE_W-1]}}, prev};
        alu_op = OP_SUB;
      end
      ST_DACC: begin
        alu_a  = delta;
        alu_b  = {{(AW-DIFF_W){diff[DIFF_W-1]}}, diff};
        alu_op = diff[DIFF_W-1] ? OP_SUB : OP_ADD;
      end
      ST_DIVM, ST_DIVF: begin
        alu_a  = {{(AW-CW-1){1'b0}}, partial};
        alu_b  = {{(AW-CW){1'b0}}, count};
        alu_op = OP_SUB;
      end
      default: begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = OP_ADD;
      end
    endcase
  end

  // restoring division step and direction decode
  assign partial  = {rem, dvd[QW-1]};
  assign q_bit    = !alu_res[AW];
  assign quo_next = {quo[QW-2:0], q_bit};
  assign nonzero  = |alu_res[AW-1:0];
  assign dir      = alu_res[AW-1] ? TR_DOWN : TR_UP;

  // period state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate     <= RATE_RESET;
      count    <= '0;
      sum      <= '0;
      delta    <= '0;
      peak     <= '0;
      prev     <= '0;
      trend    <= TR_NONE;
      turn     <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate <= cfg_wdata;
      end
      // result valid: set on a finished period, dropped once taken
      if (ctl.state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (stat.accept && stat.full) begin
        ovf <= 1'b1;
      end
      case (ctl.state)
        ST_PEAK: begin
          if (alu_res[AW]) begin
            peak <= mag;
          end
        end
        ST_AACC: sum <= alu_res[SUMW-1:0];
        ST_DIFF: begin
          if (count != '0 && nonzero) begin
            if (trend != TR_NONE && dir != trend) begin
              turn <= turn + 1'b1;
            end
            trend <= dir;
          end
        end
        ST_DACC: begin
          delta <= alu_res[AW-1:0];
          prev  <= smp;
          count <= count + 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            count    <= '0;
            sum      <= '0;
            delta    <= '0;
            peak     <= '0;
            prev     <= '0;
            trend    <= TR_NONE;
            turn     <= '0;
            ovf      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (stat.accept) begin
      smp <= s_tdata;
    end
    case (ctl.state)
      ST_MAG:  mag  <= alu_res[SAMPLE_W-1:0];
      ST_DIFF: diff <= alu_res[DIFF_W-1:0];
      ST_DIVM, ST_DIVF: begin
        quo <= quo_next;
        if (ctl.step_last) begin
          rem <= '0;
          dvd <= {rate, {(QW-RATE_W){1'b0}}};
          if (ctl.state == ST_DIVM) begin
            mean <= MEAN_W'(quo_next);
          end else begin
            freq <= RATE_W'(quo_next);
          end
        end else begin
          dvd <= {dvd[QW-2:0], 1'b0};
          rem <= q_bit ? alu_res[CW-1:0] : partial[CW-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {{(TDATA_W-PAYLOAD_W){1'b0}}, freq, TURN_W'(turn), DELTA_W'(delta),
                      SUM_W'(sum), mean, MAX_W'(peak), LEN_W'(count)};
          m_tuser <= ovf;
        end
      end
      default: begin
      end
    endcase
    if (ctl.div_start) begin
      dvd <= {sum, 8'b0};
      rem <= '0;
    end
  end

  // checks
  `PAS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_LENGTH))
  `PAS_ASSERT_IMP(a_peak_le_sum, clk, rst, ctl.state == ST_IDLE, sum >= SUMW'(peak))
  `PAS_ASSERT_IMP(a_rem_below_len, clk, rst, ctl.state == ST_DIVM || ctl.state == ST_DIVF, rem < count)
  `PAS_ASSERT_IMP(a_clear_on_result, clk, rst, $rose(m_tvalid), count == '0 && sum == '0 && turn == '0)
  `PAS_ASSERT_NXT(a_div_runs_after_last, clk, rst, ctl.div_start, ctl.state == ST_DIVM && count != '0)

endmodule

`default_nettype wire

FILE: rtl/pas_addsub.sv
// ---------------------------------------------------------------------------
// pas_addsub
// Shared add/subtract unit; top result bit is carry on add, borrow on subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module pas_addsub
  import pas_pkg::*;
#(
  parameter int W = 29
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         op,
  output logic      [W:0]   res
);

  // one adder, b inverted for subtraction
  always_comb begin
    if (op == OP_SUB) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pas_ctrl.sv
// ---------------------------------------------------------------------------
// pas_ctrl
// Sequencer: per-sample steps on the shared unit, then two restoring divisions.
// ---------------------------------------------------------------------------
`default_nettype none

module pas_ctrl
  import pas_pkg::*;
#(
  parameter int QW = 36
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pas_stat_t stat,
  output pas_ctrl_t      ctl
);

  localparam int STEP_W = $clog2(QW);

  logic [ST_W-1:0]   state;
  logic [ST_W-1:0]   state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              last_q;
  logic              div_start;

  // next state and step count
  always_comb begin
    state_next = state;
    step_next  = step;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (stat.accept) begin
          if (!stat.full) begin
            state_next = ST_MAG;
          end else if (stat.last) begin
            state_next = ST_DIVM;
            step_next  = STEP_W'(QW - 1);
            div_start  = 1'b1;
          end
        end
      end
      ST_MAG:  state_next = ST_PEAK;
      ST_PEAK: state_next = ST_AACC;
      ST_AACC: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_DACC;
      ST_DACC: begin
        if (last_q) begin
          state_next = ST_DIVM;
          step_next  = STEP_W'(QW - 1);
          div_start  = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVM: begin
        if (step == '0) begin
          state_next = ST_DIVF;
          step_next  = STEP_W'(RATE_W - 1);
        end else begin
          step_next = step - 1'b1;
        end
      end
      ST_DIVF: begin
        if (step == '0) begin
          state_next = ST_DONE;
        end else begin
          step_next = step - 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= '0;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (state == ST_IDLE && stat.accept) begin
        last_q <= stat.last;
      end
    end
  end

  assign ctl.state     = state;
  assign ctl.step_last = (step == '0);
  assign ctl.div_start = div_start;

endmodule

`default_nettype wire
